// File: rtl/core/sdpa_pkg.sv
// Shared types, constants and tables of the attention block.
`default_nettype none

package sdpa_pkg;

	localparam int D_MODEL_DEF = 16;
	localparam int SEQ_MAX_DEF = 32;

	localparam int OP_W   = 2;
	localparam int TGT_W  = 2;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 4;
	localparam int WORD_W = 16;
	localparam int LEN_W  = 6;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(32);

	localparam logic [OP_W-1:0] OP_WWRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_SWRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_RUN    = 2'd2;

	localparam logic [TGT_W-1:0] W_Q = 2'd0;
	localparam logic [TGT_W-1:0] W_K = 2'd1;
	localparam logic [TGT_W-1:0] W_V = 2'd2;
	localparam logic [TGT_W-1:0] W_O = 2'd3;

	localparam logic [TGT_W-1:0] SEQ_QUERY = 2'd0;
	localparam logic [TGT_W-1:0] SEQ_KEY   = 2'd1;
	localparam logic [TGT_W-1:0] SEQ_VALUE = 2'd2;

	localparam int ACC_W  = 32;
	localparam int SC_W   = 34;
	localparam int MA_W   = 33;
	localparam int MB_W   = 18;
	localparam int PROD_W = 51;
	localparam int NUM_W  = 34;
	localparam int E_W    = 17;
	localparam int U_LIMIT = 12 * 4096;

	typedef enum logic [1:0] {
		CMD_WWRITE,
		CMD_SWRITE,
		CMD_RUN
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t               kind;
		logic [TGT_W-1:0]        tgt;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic signed [WORD_W-1:0] data;
	} cmd_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_Q,
		B_QW,
		B_KP,
		B_KS,
		B_SC,
		B_EXP,
		B_DIV,
		B_AV,
		B_AP,
		B_AW,
		B_O,
		B_OE
	} bstate_t;

	// Scale 1/sqrt(d) in Q0.16, rounded to nearest.
	function automatic int scale_q16(input int d);
		longint lo;
		longint hi;
		longint mid;
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid * longint'(d) <= (longint'(1) << 32)) lo = mid;
			else hi = mid - 1;
		end
		if ((2 * lo + 1) * (2 * lo + 1) * longint'(d) <= (longint'(1) << 34)) lo = lo + 1;
		return int'(lo);
	endfunction

	// exp(-n), Q0.16.
	function automatic logic [E_W-1:0] expi(input logic [3:0] n);
		case (n)
			4'd0:    return 17'd65536;
			4'd1:    return 17'd24109;
			4'd2:    return 17'd8869;
			4'd3:    return 17'd3263;
			4'd4:    return 17'd1200;
			4'd5:    return 17'd442;
			4'd6:    return 17'd162;
			4'd7:    return 17'd60;
			4'd8:    return 17'd22;
			4'd9:    return 17'd8;
			4'd10:   return 17'd3;
			4'd11:   return 17'd1;
			default: return 17'd0;
		endcase
	endfunction

	// exp(-a/16), Q0.16.
	function automatic logic [E_W-1:0] expa(input logic [3:0] a);
		case (a)
			4'd0:    return 17'd65536;
			4'd1:    return 17'd61565;
			4'd2:    return 17'd57835;
			4'd3:    return 17'd54331;
			4'd4:    return 17'd51039;
			4'd5:    return 17'd47947;
			4'd6:    return 17'd45042;
			4'd7:    return 17'd42313;
			4'd8:    return 17'd39750;
			4'd9:    return 17'd37341;
			4'd10:   return 17'd35079;
			4'd11:   return 17'd32954;
			4'd12:   return 17'd30957;
			4'd13:   return 17'd29081;
			4'd14:   return 17'd27319;
			default: return 17'd25664;
		endcase
	endfunction

	// exp(-b/256), Q0.16.
	function automatic logic [E_W-1:0] expb(input logic [3:0] b);
		case (b)
			4'd0:    return 17'd65536;
			4'd1:    return 17'd65280;
			4'd2:    return 17'd65026;
			4'd3:    return 17'd64772;
			4'd4:    return 17'd64520;
			4'd5:    return 17'd64268;
			4'd6:    return 17'd64018;
			4'd7:    return 17'd63768;
			4'd8:    return 17'd63520;
			4'd9:    return 17'd63272;
			4'd10:   return 17'd63025;
			4'd11:   return 17'd62780;
			4'd12:   return 17'd62535;
			4'd13:   return 17'd62291;
			4'd14:   return 17'd62048;
			default: return 17'd61806;
		endcase
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/sdpa_if.sv
// Request and response channel interfaces of the attention block.
`default_nettype none

interface sdpa_req_if;
	import sdpa_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           op;
	logic [TGT_W-1:0]          target;
	logic [ROW_W-1:0]          row_index;
	logic [COL_W-1:0]          col_index;
	logic signed [WORD_W-1:0]  data_word;

	modport source (output valid, op, target, row_index, col_index, data_word, input ready);
	modport sink (input valid, op, target, row_index, col_index, data_word, output ready);
endinterface

interface sdpa_rsp_if;
	import sdpa_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [WORD_W-1:0]  out_word;
	logic [COL_W-1:0]          out_col;
	logic                      saturated;
	logic                      last;

	modport source (output valid, out_word, out_col, saturated, last, input ready);
	modport sink (input valid, out_word, out_col, saturated, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sdpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sdpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

// File: rtl/core/sdpa_front.sv
// Front end: accepts request words, drops the ones with no effect, queues the rest.
`default_nettype none

module sdpa_front #(
	parameter int D_MODEL = sdpa_pkg::D_MODEL_DEF,
	parameter int SEQ_MAX = sdpa_pkg::SEQ_MAX_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	sdpa_req_if.sink       req,
	output logic           head_valid,
	output sdpa_pkg::cmd_t head,
	input  logic           pop
);
	import sdpa_pkg::*;

	cmd_t       fifo_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	cmd_t       cmd;
	logic       keep;
	logic       push;

	always_comb begin
		cmd.tgt  = req.target;
		cmd.row  = req.row_index;
		cmd.col  = req.col_index;
		cmd.data = req.data_word;
		cmd.kind = CMD_RUN;
		keep     = 1'b0;
		case (req.op)
			OP_WWRITE: begin
				cmd.kind = CMD_WWRITE;
				keep = int'(req.row_index) < D_MODEL && int'(req.col_index) < D_MODEL;
			end
			OP_SWRITE: begin
				cmd.kind = CMD_SWRITE;
				keep = req.target != 2'd3 && int'(req.row_index) < SEQ_MAX
					&& int'(req.col_index) < D_MODEL;
			end
			OP_RUN: begin
				cmd.kind = CMD_RUN;
				keep = int'(req.row_index) < SEQ_MAX;
			end
			default: keep = 1'b0;
		endcase
	end

	assign req.ready  = cnt_q != 2'd2;
	assign push       = req.valid && req.ready && keep;
	assign head_valid = cnt_q != 2'd0;
	assign head       = fifo_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wptr_q] <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

`default_nettype wire

// File: rtl/core/sdpa_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module sdpa_div #(
	parameter int NUM_W = 34,
	parameter int DEN_W = 22
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign done  = done_q;
	assign quot  = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
				cnt_q  <= CNT_W'(NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
				num_q <= {num_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

`default_nettype wire

// File: rtl/core/sdpa_back.sv
// Back end: stores, multiply-accumulate sequencer, softmax and output register.
`default_nettype none

module sdpa_back #(
	parameter int D_MODEL = sdpa_pkg::D_MODEL_DEF,
	parameter int SEQ_MAX = sdpa_pkg::SEQ_MAX_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [sdpa_pkg::LEN_W-1:0]   active_length,
	input  logic                         head_valid,
	input  sdpa_pkg::cmd_t               head,
	output logic                         pop,
	sdpa_rsp_if.source                   rsp
);
	import sdpa_pkg::*;

	localparam int DI_W   = D_MODEL > 1 ? $clog2(D_MODEL) : 1;
	localparam int SI_W   = SEQ_MAX > 1 ? $clog2(SEQ_MAX) : 1;
	localparam int WDEPTH = 4 * D_MODEL * D_MODEL;
	localparam int SDEPTH = 3 * SEQ_MAX * D_MODEL;
	localparam int WA_W   = $clog2(WDEPTH);
	localparam int SA_W   = $clog2(SDEPTH);
	localparam int SUM_W  = $clog2(SEQ_MAX) + 17;
	localparam logic signed [MB_W-1:0] SCALE_B = MB_W'(scale_q16(D_MODEL));

	function automatic logic [WORD_W:0] sat16(input logic signed [ACC_W-1:0] v);
		if (v > 32767) return {1'b1, 16'h7fff};
		else if (v < -32768) return {1'b1, 16'h8000};
		else return {1'b0, v[WORD_W-1:0]};
	endfunction

	bstate_t st_q, st_d;
	logic [1:0]                ph_q;
	logic [DI_W-1:0]           col_q, m_q;
	logic [SI_W-1:0]           j_q;
	logic [ROW_W-1:0]          row_q;
	logic signed [ACC_W-1:0]   acc_q, acc2_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [SC_W-1:0]    mx_q;
	logic [SUM_W-1:0]          sum_q;
	logic [3:0]                eb_q;
	logic                      rv_q;
	logic signed [WORD_W-1:0]  rword_q;
	logic [COL_W-1:0]          rcol_q;
	logic                      rsat_q, rlast_q;

	logic [SI_W:0]             len_c;
	logic                      last_m, last_col, last_j, mac_end, out_free;
	logic signed [ACC_W-1:0]   r12;
	logic signed [SC_W-1:0]    r16;
	logic signed [SC_W:0]      u;
	logic                      u_big;
	logic signed [MA_W-1:0]    mul_a;
	logic signed [MB_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic [WORD_W:0]           sat_acc, sat_acc2;

	logic             w_we, s_we, q_we, sc_we, att_we;
	logic [1:0]       w_tgt, s_tgt;
	logic [ROW_W-1:0] s_row;
	logic [WA_W-1:0]  w_waddr, w_raddr;
	logic [SA_W-1:0]  s_waddr, s_raddr;
	logic [WORD_W-1:0] w_rdata, s_rdata, q_rdata, att_rdata;
	logic [SC_W-1:0]  sc_rdata, sc_wdata;
	logic signed [SC_W-1:0] sc_sd;
	logic             div_start, div_done;
	logic [NUM_W-1:0] div_num, div_quot;

	always_comb begin
		if (active_length == '0) len_c = (SI_W + 1)'(1);
		else if (int'(active_length) > SEQ_MAX) len_c = (SI_W + 1)'(SEQ_MAX);
		else len_c = (SI_W + 1)'(active_length);
	end

	assign last_m   = m_q == DI_W'(D_MODEL - 1);
	assign last_col = col_q == DI_W'(D_MODEL - 1);
	assign last_j   = {1'b0, j_q} == len_c - 1'b1;
	assign mac_end  = ph_q == 2'd2 && last_m;
	assign out_free = !rv_q || rsp.ready;

	assign r12      = ACC_W'((prod_q + PROD_W'(2048)) >>> 12);
	assign r16      = SC_W'((prod_q + PROD_W'(32768)) >>> 16);
	assign sc_sd    = $signed(sc_rdata);
	assign u        = {mx_q[SC_W-1], mx_q} - {sc_sd[SC_W-1], sc_sd};
	assign u_big    = u >= (SC_W + 1)'(U_LIMIT);
	assign sat_acc  = sat16(acc_q);
	assign sat_acc2 = sat16(acc2_q);
	assign mul_p    = mul_a * mul_b;

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			B_IDLE: if (head_valid && head.kind == CMD_RUN) st_d = B_Q;
			B_Q:    if (mac_end) st_d = B_QW;
			B_QW:   st_d = last_col ? B_KP : B_Q;
			B_KP:   if (mac_end) st_d = B_KS;
			B_KS:   if (ph_q == 2'd1) st_d = last_col ? B_SC : B_KP;
			B_SC:   if (ph_q == 2'd1) st_d = last_j ? B_EXP : B_KP;
			B_EXP: begin
				if ((ph_q == 2'd1 && u_big) || ph_q == 2'd3) st_d = last_j ? B_DIV : B_EXP;
			end
			B_DIV:  if (ph_q == 2'd3) st_d = last_j ? B_AV : B_DIV;
			B_AV:   if (mac_end) st_d = B_AP;
			B_AP:   if (ph_q == 2'd1) st_d = last_j ? B_AW : B_AV;
			B_AW:   st_d = last_col ? B_O : B_AV;
			B_O:    if (mac_end) st_d = B_OE;
			B_OE:   if (out_free) st_d = last_col ? B_IDLE : B_O;
			default: st_d = B_IDLE;
		endcase
	end

	// Store addressing, writes and multiplier operands.
	always_comb begin
		pop       = st_q == B_IDLE && head_valid;
		w_we      = pop && head.kind == CMD_WWRITE;
		s_we      = pop && head.kind == CMD_SWRITE;
		w_waddr   = WA_W'((int'(head.tgt) * D_MODEL + int'(head.row)) * D_MODEL
			+ int'(head.col));
		s_waddr   = SA_W'((int'(head.tgt) * SEQ_MAX + int'(head.row)) * D_MODEL
			+ int'(head.col));
		w_tgt     = W_Q;
		s_tgt     = SEQ_QUERY;
		s_row     = row_q;
		q_we      = st_q == B_QW;
		att_we    = st_q == B_AW;
		sc_we     = 1'b0;
		sc_wdata  = r16;
		div_start = st_q == B_DIV && ph_q == 2'd1;
		div_num   = NUM_W'({sc_rdata[E_W-1:0], 16'b0}) + NUM_W'(sum_q >> 1);
		mul_a     = MA_W'($signed(s_rdata));
		mul_b     = MB_W'($signed(w_rdata));
		case (st_q)
			B_KP: begin
				w_tgt = W_K;
				s_tgt = SEQ_KEY;
				s_row = ROW_W'(j_q);
			end
			B_AV: begin
				w_tgt = W_V;
				s_tgt = SEQ_VALUE;
				s_row = ROW_W'(j_q);
			end
			B_O: begin
				w_tgt = W_O;
				mul_a = MA_W'($signed(att_rdata));
			end
			B_KS: begin
				mul_a = MA_W'($signed(q_rdata));
				mul_b = MB_W'($signed(sat_acc[WORD_W-1:0]));
			end
			B_SC: begin
				mul_a = MA_W'(acc2_q);
				mul_b = SCALE_B;
				sc_we = ph_q == 2'd1;
			end
			B_EXP: begin
				if (ph_q == 2'd2) begin
					mul_a = MA_W'(r16);
					mul_b = $signed({1'b0, expb(eb_q)});
				end else begin
					mul_a = MA_W'($signed({1'b0, expi(u[15:12])}));
					mul_b = $signed({1'b0, expa(u[11:8])});
				end
				sc_we = (ph_q == 2'd1 && u_big) || ph_q == 2'd3;
				if (ph_q == 2'd1) sc_wdata = '0;
			end
			B_DIV: begin
				sc_we    = ph_q == 2'd3;
				sc_wdata = SC_W'(div_quot[E_W-1:0]);
			end
			B_AP: begin
				mul_a = MA_W'($signed(sat_acc[WORD_W-1:0]));
				mul_b = $signed({1'b0, sc_rdata[E_W-1:0]});
			end
			default: ;
		endcase
		w_raddr = WA_W'((int'(w_tgt) * D_MODEL + int'(m_q)) * D_MODEL + int'(col_q));
		s_raddr = SA_W'((int'(s_tgt) * SEQ_MAX + int'(s_row)) * D_MODEL + int'(m_q));
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= B_IDLE;
			ph_q    <= 2'd0;
			col_q   <= '0;
			m_q     <= '0;
			j_q     <= '0;
			row_q   <= '0;
			acc_q   <= '0;
			acc2_q  <= '0;
			mx_q    <= '0;
			sum_q   <= '0;
			eb_q    <= '0;
			rv_q    <= 1'b0;
			rword_q <= '0;
			rcol_q  <= '0;
			rsat_q  <= 1'b0;
			rlast_q <= 1'b0;
		end else begin
			st_q <= st_d;
			// In B_OE a stalled word is only replaced once it has been taken.
			if (rsp.ready && st_q != B_OE) rv_q <= 1'b0;
			case (st_q)
				B_IDLE: begin
					if (head_valid && head.kind == CMD_RUN) begin
						row_q  <= head.row;
						col_q  <= '0;
						m_q    <= '0;
						j_q    <= '0;
						ph_q   <= 2'd0;
						acc_q  <= '0;
						acc2_q <= '0;
						sum_q  <= '0;
					end
				end
				B_Q, B_KP, B_AV, B_O: begin
					case (ph_q)
						2'd0: ph_q <= 2'd1;
						2'd1: ph_q <= 2'd2;
						default: begin
							acc_q <= acc_q + r12;
							ph_q  <= 2'd0;
							m_q   <= last_m ? '0 : m_q + 1'b1;
						end
					endcase
				end
				B_QW: begin
					acc_q <= '0;
					col_q <= last_col ? '0 : col_q + 1'b1;
				end
				B_KS: begin
					if (ph_q == 2'd0) ph_q <= 2'd1;
					else begin
						acc2_q <= acc2_q + r12;
						acc_q  <= '0;
						ph_q   <= 2'd0;
						col_q  <= last_col ? '0 : col_q + 1'b1;
					end
				end
				B_SC: begin
					if (ph_q == 2'd0) ph_q <= 2'd1;
					else begin
						if (j_q == '0 || r16 > mx_q) mx_q <= r16;
						acc2_q <= '0;
						ph_q   <= 2'd0;
						j_q    <= last_j ? '0 : j_q + 1'b1;
					end
				end
				B_EXP: begin
					case (ph_q)
						2'd0: ph_q <= 2'd1;
						2'd1: begin
							if (u_big) begin
								ph_q <= 2'd0;
								j_q  <= last_j ? '0 : j_q + 1'b1;
							end else begin
								eb_q <= u[7:4];
								ph_q <= 2'd2;
							end
						end
						2'd2: ph_q <= 2'd3;
						default: begin
							sum_q <= sum_q + SUM_W'(r16[E_W-1:0]);
							ph_q  <= 2'd0;
							j_q   <= last_j ? '0 : j_q + 1'b1;
						end
					endcase
				end
				B_DIV: begin
					case (ph_q)
						2'd0: ph_q <= 2'd1;
						2'd1: ph_q <= 2'd2;
						2'd2: if (div_done) ph_q <= 2'd3;
						default: begin
							ph_q <= 2'd0;
							j_q  <= last_j ? '0 : j_q + 1'b1;
						end
					endcase
				end
				B_AP: begin
					if (ph_q == 2'd0) ph_q <= 2'd1;
					else begin
						acc2_q <= acc2_q + ACC_W'(r16);
						acc_q  <= '0;
						ph_q   <= 2'd0;
						j_q    <= last_j ? '0 : j_q + 1'b1;
					end
				end
				B_AW: begin
					acc2_q <= '0;
					col_q  <= last_col ? '0 : col_q + 1'b1;
				end
				B_OE: begin
					if (out_free) begin
						rv_q    <= 1'b1;
						rword_q <= $signed(sat_acc[WORD_W-1:0]);
						rsat_q  <= sat_acc[WORD_W];
						rcol_q  <= COL_W'(col_q);
						rlast_q <= last_col;
						acc_q   <= '0;
						col_q   <= last_col ? '0 : col_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign rsp.valid     = rv_q;
	assign rsp.out_word  = rword_q;
	assign rsp.out_col   = rcol_q;
	assign rsp.saturated = rsat_q;
	assign rsp.last      = rlast_q;

	sdpa_ram #(.WIDTH(WORD_W), .DEPTH(WDEPTH)) u_wram (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(head.data),
		.raddr(w_raddr), .rdata(w_rdata)
	);

	sdpa_ram #(.WIDTH(WORD_W), .DEPTH(SDEPTH)) u_sram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(head.data),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	sdpa_ram #(.WIDTH(WORD_W), .DEPTH(D_MODEL)) u_qram (
		.clk(clk), .we(q_we), .waddr(col_q), .wdata(sat_acc[WORD_W-1:0]),
		.raddr(col_q), .rdata(q_rdata)
	);

	sdpa_ram #(.WIDTH(SC_W), .DEPTH(SEQ_MAX)) u_scram (
		.clk(clk), .we(sc_we), .waddr(j_q), .wdata(sc_wdata),
		.raddr(j_q), .rdata(sc_rdata)
	);

	sdpa_ram #(.WIDTH(WORD_W), .DEPTH(D_MODEL)) u_attram (
		.clk(clk), .we(att_we), .waddr(col_q), .wdata(sat_acc2[WORD_W-1:0]),
		.raddr(m_q), .rdata(att_rdata)
	);

	sdpa_div #(.NUM_W(NUM_W), .DEN_W(SUM_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(sum_q), .done(div_done), .quot(div_quot)
	);
endmodule

`default_nettype wire

// File: rtl/core/scaled_dot_product_attention.sv
// Top level of the single-head fixed-point attention block.
//
// Requests arrive on req, one word per valid/ready handshake. A weight-write or
// sequence-write word stores one Q4.12 element; writes with an out-of-range row
// or column, and unused op codes, are dropped. A compute word names a query row
// and produces D_MODEL response words on rsp, columns 0..D_MODEL-1 in order,
// the final one marked by last. cfg_we/cfg_data load the active length.
// The front end queues up to two words behind the one the back end is working
// on, so req stays ready during a compute until two words are waiting. The back
// end stores a write as it takes it from the queue. The run time of a compute is
// set by the single multiply-accumulate unit, which forms one product at a time,
// and by the bit-serial divider that forms each softmax weight.
// Response words sit in an output register; while rsp is stalled the back end
// holds at the next column and the queue keeps taking words until it is full.
// Reset clears the queue and the sequencer and sets the active length to 32;
// the weight and sequence stores keep no reset value and must be written
// before they are read.
`default_nettype none

module scaled_dot_product_attention #(
	parameter int D_MODEL = sdpa_pkg::D_MODEL_DEF,
	parameter int SEQ_MAX = sdpa_pkg::SEQ_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [sdpa_pkg::LEN_W-1:0] cfg_data,
	sdpa_req_if.sink                   req,
	sdpa_rsp_if.source                 rsp
);
	import sdpa_pkg::*;

	logic [LEN_W-1:0] len_q;
	logic             head_valid;
	cmd_t             head;
	logic             pop;

	// The user must change the active length only while the block is idle; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) len_q <= LEN_RESET;
		else if (cfg_we) len_q <= cfg_data;
	end

	sdpa_front #(.D_MODEL(D_MODEL), .SEQ_MAX(SEQ_MAX)) u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.head_valid(head_valid), .head(head), .pop(pop)
	);

	sdpa_back #(.D_MODEL(D_MODEL), .SEQ_MAX(SEQ_MAX)) u_back (
		.clk(clk), .arst_n(arst_n), .active_length(len_q),
		.head_valid(head_valid), .head(head), .pop(pop), .rsp(rsp)
	);

	// The back end never takes a word from an empty queue.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	// The last flag marks exactly the final column of a row.
	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.last == (rsp.out_col == COL_W'(D_MODEL - 1))))
		else $error("last flag does not match final column");

	// A clipped word sits at one of the two range limits.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.saturated |->
			(rsp.out_word == 16'sh7fff || rsp.out_word == 16'sh8000))
		else $error("saturated word not at a limit");
endmodule

`default_nettype wire

// File: bench/sdpa_checker.sv
// Checker that watches the attention channels, predicts every output row and compares it.
module sdpa_checker
	import sdpa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_data,
	sdpa_req_if              req,
	sdpa_rsp_if              rsp,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DM = 16;
	localparam int SQ = 32;
	// 1/sqrt(16) in Q0.16.
	localparam longint SCORE_SCALE = 16384;

	typedef struct {
		logic signed [WORD_W-1:0] word;
		logic [COL_W-1:0]         col;
		logic                     sat;
		logic                     last;
	} out_elem_t;

	const longint exp_int[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
	const longint exp_hi[16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
		39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
	const longint exp_lo[16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
		63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};

	shortint weights[4][DM][DM];
	shortint seq_words[3][SQ][DM];
	logic [LEN_W-1:0] length_reg;
	out_elem_t row_words[$];

	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip16(longint v, output logic hit);
		hit = 1'b0;
		if (v > 32767) begin
			hit = 1'b1;
			return 32767;
		end
		if (v < -32768) begin
			hit = 1'b1;
			return -32768;
		end
		return v;
	endfunction

	// Sequence row r of store t projected through weight matrix w, column c.
	function automatic longint project(int t, int r, int w, int c);
		longint acc;
		logic hit;
		acc = 0;
		for (int m = 0; m < DM; m++)
			acc += round_shift(longint'(seq_words[t][r][m]) * longint'(weights[w][m][c]), 12);
		return clip16(acc, hit);
	endfunction

	function automatic longint exp_neg(longint u);
		longint e;
		if ((u >>> 12) >= 12) return 0;
		e = round_shift(exp_int[u >>> 12] * exp_hi[(u >>> 8) & 15], 16);
		return round_shift(e * exp_lo[(u >>> 4) & 15], 16);
	endfunction

	task automatic predict_row(int row);
		longint q[DM];
		longint kv[SQ][DM];
		longint vv[SQ][DM];
		longint w[SQ];
		longint att[DM];
		longint acc, mx, sum;
		int n;
		logic hit;
		out_elem_t e;
		n = int'(length_reg);
		if (n < 1) n = 1;
		if (n > SQ) n = SQ;
		for (int k = 0; k < DM; k++) q[k] = project(0, row, 0, k);
		for (int j = 0; j < n; j++)
			for (int k = 0; k < DM; k++) begin
				kv[j][k] = project(1, j, 1, k);
				vv[j][k] = project(2, j, 2, k);
			end
		mx = 0;
		for (int j = 0; j < n; j++) begin
			acc = 0;
			for (int k = 0; k < DM; k++) acc += round_shift(q[k] * kv[j][k], 12);
			w[j] = round_shift(acc * SCORE_SCALE, 16);
			if (j == 0 || w[j] > mx) mx = w[j];
		end
		sum = 0;
		for (int j = 0; j < n; j++) begin
			w[j] = exp_neg(mx - w[j]);
			sum += w[j];
		end
		// The peak position contributes exactly 1.0, so sum is at least 65536.
		for (int j = 0; j < n; j++) w[j] = (w[j] * 65536 + sum / 2) / sum;
		for (int k = 0; k < DM; k++) begin
			acc = 0;
			for (int j = 0; j < n; j++) acc += round_shift(w[j] * vv[j][k], 16);
			att[k] = clip16(acc, hit);
		end
		for (int c = 0; c < DM; c++) begin
			acc = 0;
			for (int k = 0; k < DM; k++)
				acc += round_shift(att[k] * longint'(weights[3][k][c]), 12);
			e.word = WORD_W'(clip16(acc, hit));
			e.sat = hit;
			e.col = COL_W'(c);
			e.last = (c == DM - 1);
			row_words.push_back(e);
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		length_reg = LEN_RESET;
	end

	always @(posedge clk) begin
		out_elem_t exp_w;
		if (!arst_n) begin
			length_reg = LEN_RESET;
		end else begin
			if (cfg_we) length_reg = cfg_data;
			if (req.valid && req.ready) begin
				case (req.op)
					OP_WWRITE: if (req.row_index < DM)
						weights[req.target][req.row_index][req.col_index] = req.data_word;
					OP_SWRITE: if (req.target != 2'd3)
						seq_words[req.target][req.row_index][req.col_index] = req.data_word;
					OP_RUN: predict_row(int'(req.row_index));
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (row_words.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected output word %0d col %0d", $time,
						rsp.out_word, rsp.out_col);
				end else begin
					exp_w = row_words.pop_front();
					if (rsp.out_word !== exp_w.word || rsp.out_col !== exp_w.col
							|| rsp.saturated !== exp_w.sat || rsp.last !== exp_w.last) begin
						fail_count++;
						$display("%0t: expected word %0d col %0d sat %0b last %0b, got %0d col %0d sat %0b last %0b",
							$time, exp_w.word, exp_w.col, exp_w.sat, exp_w.last,
							rsp.out_word, rsp.out_col, rsp.saturated, rsp.last);
					end
				end
			end
		end
		pending = row_words.size();
	end
endmodule

// File: bench/scaled_dot_product_attention_tb.sv
// Testbench top: drives the attention block and gives the verdict.
module scaled_dot_product_attention_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sdpa_pkg::*;

	// Op code and sequence target that the block must ignore.
	localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
	localparam logic [TGT_W-1:0] SEQ_NONE  = 2'd3;
	// The watchdog limit must cover a compute at full length, during which no word moves.
	localparam int STALL_LIMIT = 200000;
	localparam int SETTLE = 30;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [LEN_W-1:0] cfg_data;
	int fail_count;
	int pending;
	int idle_cycles;
	int stall_left;
	bit quiet;
	bit calm;

	sdpa_req_if req_ch();
	sdpa_rsp_if rsp_ch();

	scaled_dot_product_attention dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.req(req_ch), .rsp(rsp_ch)
	);

	sdpa_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.req(req_ch), .rsp(rsp_ch), .fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Response side: ready drops in random bursts, except in calm stretches and in
	// the final part of the run.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 12);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Watchdog: a long stretch without any word moving means the block hung.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Mostly modest values so that results do not all clip; now and then any value.
	function automatic logic signed [WORD_W-1:0] pick_word();
		if ($urandom_range(0, 3) == 0) return WORD_W'($urandom);
		return WORD_W'(int'($urandom_range(0, 4095)) - 2048);
	endfunction

	// Offer one request word and hold it until the block takes it; sometimes
	// follow it with an idle burst on the request side.
	task automatic send_word(logic [OP_W-1:0] op, logic [TGT_W-1:0] tgt,
			logic [ROW_W-1:0] row, logic [COL_W-1:0] col, logic signed [WORD_W-1:0] data);
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.target <= tgt;
		req_ch.row_index <= row;
		req_ch.col_index <= col;
		req_ch.data_word <= data;
		do @(posedge clk); while (!req_ch.ready);
		if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// Wait until every predicted word has come back, then let any write still
	// queued in the front end retire before touching the length register.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_length(logic [LEN_W-1:0] len);
		cfg_we <= 1'b1;
		cfg_data <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int sent;
		int pick;
		req_ch.valid = 1'b0;
		req_ch.op = OP_WWRITE;
		req_ch.target = W_Q;
		req_ch.row_index = '0;
		req_ch.col_index = '0;
		req_ch.data_word = '0;
		rsp_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		stall_left = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		calm = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill both stores completely so that no compute ever reads an unwritten word.
		for (int t = 0; t < 4; t++)
			for (int r = 0; r < 16; r++)
				for (int c = 0; c < 16; c++)
					send_word(OP_WWRITE, TGT_W'(t), ROW_W'(r), COL_W'(c), pick_word());
		for (int t = 0; t < 3; t++)
			for (int r = 0; r < 32; r++)
				for (int c = 0; c < 16; c++)
					send_word(OP_SWRITE, TGT_W'(t), ROW_W'(r), COL_W'(c), pick_word());

		// Directed words: extreme data, ignored writes, the unused op, and a
		// compute at the reset length of 32.
		send_word(OP_WWRITE, W_Q, 5'd0, 4'd0, -16'sd32768);
		send_word(OP_WWRITE, W_O, 5'd15, 4'd15, 16'sd32767);
		send_word(OP_WWRITE, W_K, 5'd31, 4'd3, 16'sd1234);
		send_word(OP_WWRITE, W_V, 5'd16, 4'd15, -16'sd1);
		send_word(OP_SWRITE, SEQ_NONE, 5'd4, 4'd7, 16'sd4096);
		send_word(OP_SWRITE, SEQ_VALUE, 5'd31, 4'd15, 16'sd32767);
		send_word(OP_SWRITE, SEQ_KEY, 5'd0, 4'd0, -16'sd32768);
		send_word(OP_SWRITE, SEQ_QUERY, 5'd31, 4'd9, 16'sd4096);
		send_word(OP_UNUSED, SEQ_NONE, 5'd31, 4'd15, -16'sd1);
		send_word(OP_RUN, W_Q, 5'd0, 4'd0, '0);
		drain();

		// A zero length acts as one; the last query row lies past the active length.
		set_length(6'd0);
		send_word(OP_RUN, W_Q, 5'd31, 4'd0, '0);
		send_word(OP_RUN, W_Q, 5'd1, 4'd15, '0);
		drain();

		// A length above the sequence size acts as the full size.
		set_length(6'd63);
		send_word(OP_RUN, W_Q, 5'd17, 4'd0, '0);
		drain();

		// Random phases at short active lengths, from 1 to 5.
		sent = 0;
		while (sent < 170) begin
			calm = ($urandom_range(0, 3) == 0);
			if (sent >= 130) quiet = 1'b1;
			set_length(LEN_W'($urandom_range(1, 5)));
			for (int i = 0; i < 34; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 12)
					send_word(OP_RUN, TGT_W'($urandom), ROW_W'($urandom), COL_W'($urandom), '0);
				else if (pick < 15)
					send_word(OP_UNUSED, TGT_W'($urandom), ROW_W'($urandom),
						COL_W'($urandom), pick_word());
				else if (pick < 55)
					send_word(OP_WWRITE, TGT_W'($urandom), ROW_W'($urandom),
						COL_W'($urandom), pick_word());
				else
					send_word(OP_SWRITE, TGT_W'($urandom), ROW_W'($urandom),
						COL_W'($urandom), pick_word());
				sent++;
			end
			drain();
		end

		quiet = 1'b1;
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
